// File: design/framed_packet_parser_crc16_defines.svh
// Assertion macros for the framed packet parser RTL.
`ifndef FRAMED_PACKET_PARSER_CRC16_DEFINES_SVH
`define FRAMED_PACKET_PARSER_CRC16_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fpp_pkg.sv
// Types, codes and the CRC16-Modbus byte update for the framed packet parser.
package fpp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Frame phases
    localparam logic [PHASE_W-1:0] PH_HUNT    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CMD     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SEQ     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CRC_LO  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CRC_HI  = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [LEN_W-1:0]  max_payload;
    } t_cfg;

    typedef struct packed {
        logic              frame_ok;
        logic [BYTE_W-1:0] frame_cmd;
        logic [BYTE_W-1:0] frame_seq;
        logic [LEN_W-1:0]  frame_len;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_data;
        logic [BYTE_W-1:0] payload_index;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               take;
        logic               ok;
        logic               pvalid;
    } t_core_status;

    // Reflected CRC16, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/fpp_ifs.sv
// Valid/ready channel interfaces: received bytes, parser results, register writes.
interface fpp_in_if import fpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

interface fpp_out_if import fpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              frame_ok;
    logic [BYTE_W-1:0] frame_cmd;
    logic [BYTE_W-1:0] frame_seq;
    logic [LEN_W-1:0]  frame_len;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_data;
    logic [BYTE_W-1:0] payload_index;

    modport source(output valid, output frame_ok, output frame_cmd, output frame_seq,
                   output frame_len, output payload_valid, output payload_data,
                   output payload_index, input ready);
    modport sink(input valid, input frame_ok, input frame_cmd, input frame_seq,
                 input frame_len, input payload_valid, input payload_data,
                 input payload_index, output ready);
endinterface

interface fpp_cfg_if import fpp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    modport source(output valid, output cfg_index, output cfg_data, input ready);
    modport sink(input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: design/framed_packet_parser_crc16.sv
// Framed packet parser with running CRC16-Modbus check, top level.
//
// Channels (valid/ready, transaction when both are high at a clock edge):
//   i_in   - one received byte per transaction.
//   o_out  - one result per accepted byte: held frame command, sequence and
//            length, payload byte with its index when the byte is payload,
//            and frame_ok on the last CRC byte of a frame whose CRC matched.
//   i_cfg  - register writes: 0 header_first, 1 header_second, 2 max_payload.
//            Always ready; write only while no byte is in flight.
// A byte accepted into the input register is parsed and lands in the result
// register once the output is free, from which its result is offered on o_out.
// Throughput: one byte per cycle while o_out is taken; the phase step and
// byte-wide CRC update sit between the input register and the result register.
// Stall: when o_out is not taken, the result holds, the input register keeps
// its byte, and i_in.ready drops once that register is occupied.
// Reset (i_rst_n low, synchronous): hunting for the first header, frame
// fields zero, CRC at 0xFFFF, registers back to 0xAA, 0x55 and 256.
`include "framed_packet_parser_crc16_defines.svh"

module framed_packet_parser_crc16 import fpp_pkg::*; #(
    parameter int MAX_PAYLOAD_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpp_in_if.sink    i_in,
    fpp_out_if.source o_out,
    fpp_cfg_if.sink   i_cfg
);

    t_cfg              cfg;
    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    logic              core_take;
    logic              out_valid;
    t_result           result;
    t_core_status      status;

    fpp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.cfg_index),
        .i_data  (i_cfg.cfg_data),
        .o_cfg   (cfg)
    );

    fpp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_byte  (i_in.in_byte),
        .o_valid (stage_valid),
        .o_byte  (stage_byte),
        .i_take  (core_take)
    );

    fpp_core #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_byte      (stage_byte),
        .o_take      (core_take),
        .i_cfg       (cfg),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_result    (result),
        .o_status    (status)
    );

    assign o_out.valid         = out_valid;
    assign o_out.frame_ok      = result.frame_ok;
    assign o_out.frame_cmd     = result.frame_cmd;
    assign o_out.frame_seq     = result.frame_seq;
    assign o_out.frame_len     = result.frame_len;
    assign o_out.payload_valid = result.payload_valid;
    assign o_out.payload_data  = result.payload_data;
    assign o_out.payload_index = result.payload_index;

    // payload index always lies inside the announced length
    `FPP_ASSERT_NOW(a_index_in_len, out_valid && result.payload_valid, ({1'b0, result.payload_index} < result.frame_len), "payload index outside frame length")

    // a checked frame ends the frame
    `FPP_ASSERT_NEXT(a_ok_ends_frame, status.take && status.ok, status.phase == PH_HUNT, "frame_ok without return to hunt")

    // a payload byte leaves the parser in payload or CRC phase
    `FPP_ASSERT_NEXT(a_payload_phase, status.take && status.pvalid, (status.phase == PH_PAYLOAD || status.phase == PH_CRC_LO), "payload byte outside payload phase")

endmodule

// File: design/fpp_cfg_regs.sv
// Configuration registers: header bytes and payload length limit.
module fpp_cfg_regs import fpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= 8'hAA;
            r_cfg.header_second <= 8'h55;
            r_cfg.max_payload   <= 9'd256;
        end else if (i_valid) begin
            case (i_index)
                CFG_HEADER_FIRST:  r_cfg.header_first  <= i_data[BYTE_W-1:0];
                CFG_HEADER_SECOND: r_cfg.header_second <= i_data[BYTE_W-1:0];
                CFG_MAX_PAYLOAD:   r_cfg.max_payload   <= i_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: design/fpp_in_stage.sv
// Input register for received bytes.
module fpp_in_stage import fpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    input  logic              i_take
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // Refill in the same cycle the held byte moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: design/fpp_core.sv
// Frame parser state, running CRC and result register.
module fpp_core import fpp_pkg::*; #(
    parameter int MAX_PAYLOAD_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_take,
    input  t_cfg              i_cfg,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_result           o_result,
    output t_core_status      o_status
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_cmd, n_cmd;
    logic [BYTE_W-1:0]  r_seq, n_seq;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [BYTE_W-1:0]  r_crc_lo, n_crc_lo;
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic [CRC_W-1:0]   crc_cont;
    logic [CRC_W-1:0]   crc_restart;
    logic [CRC_W-1:0]   full_len;
    logic               over_limit;
    logic [LEN_W-1:0]   count_inc;
    logic               take;

    assign take     = i_valid && (!r_out_valid || i_out_ready);
    assign o_take   = take;

    assign crc_cont    = crc16_byte(r_crc, i_byte);
    assign crc_restart = crc16_byte(CRC_INIT, i_byte);
    assign full_len    = {r_len[BYTE_W-1:0], i_byte};
    // Limit is the smaller of the register and the build-time cap
    assign over_limit  = (full_len > {{(CRC_W-LEN_W){1'b0}}, i_cfg.max_payload})
                      || ({16'd0, full_len} > 32'(MAX_PAYLOAD_BYTES));
    assign count_inc   = r_count + 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_seq    = r_seq;
        n_len    = r_len;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_result = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.header_first) begin
                    n_crc   = crc_restart;
                    n_phase = PH_HDR2;
                end
            end
            PH_HDR2: begin
                if (i_byte == i_cfg.header_second) begin
                    n_crc   = crc_cont;
                    n_phase = PH_CMD;
                end else if (i_byte == i_cfg.header_first) begin
                    // repeated first header byte: restart, stay armed
                    n_crc   = crc_restart;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_crc   = crc_cont;
                n_phase = PH_SEQ;
            end
            PH_SEQ: begin
                n_seq   = i_byte;
                n_crc   = crc_cont;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {1'b0, i_byte};
                n_crc   = crc_cont;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_crc   = crc_cont;
                n_count = '0;
                if (over_limit) begin
                    n_len   = '0;
                    n_phase = PH_HUNT;
                end else begin
                    n_len   = full_len[LEN_W-1:0];
                    n_phase = (full_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_result.payload_valid = 1'b1;
                n_result.payload_data  = i_byte;
                n_result.payload_index = r_count[BYTE_W-1:0];
                n_crc   = crc_cont;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_result.frame_ok = ({i_byte, r_crc_lo} == r_crc);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        n_result.frame_cmd = n_cmd;
        n_result.frame_seq = n_seq;
        n_result.frame_len = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_cmd       <= '0;
            r_seq       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_crc_lo    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase  <= n_phase;
                r_cmd    <= n_cmd;
                r_seq    <= n_seq;
                r_len    <= n_len;
                r_count  <= n_count;
                r_crc    <= n_crc;
                r_crc_lo <= n_crc_lo;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign o_status.phase  = r_phase;
    assign o_status.take   = take;
    assign o_status.ok     = n_result.frame_ok;
    assign o_status.pvalid = n_result.payload_valid;

endmodule
